// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: codes, micro-op table, shared types.
package rau_pkg;

	localparam int RAU_WIDTH = 32;

	// Operation codes on the kind field
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_OVF      = 2'd3;

	localparam int RF_DEPTH = 8;
	localparam int RF_AW    = 3;
	localparam int PC_W     = 5;

	// Program entry points
	localparam logic [PC_W-1:0] PC_SUM = 5'd0;
	localparam logic [PC_W-1:0] PC_MUL = 5'd16;

	// Register file slots
	localparam logic [RF_AW-1:0] R_AN = 3'd0;
	localparam logic [RF_AW-1:0] R_AD = 3'd1;
	localparam logic [RF_AW-1:0] R_BN = 3'd2;
	localparam logic [RF_AW-1:0] R_BD = 3'd3;
	localparam logic [RF_AW-1:0] R_G  = 3'd4;
	localparam logic [RF_AW-1:0] R_G1 = 3'd5;
	localparam logic [RF_AW-1:0] R_T1 = 3'd6;
	localparam logic [RF_AW-1:0] R_T2 = 3'd7;

	typedef enum logic [1:0] {
		UOP_GCD = 2'd0,
		UOP_DIV = 2'd1,
		UOP_MUL = 2'd2,
		UOP_ADD = 2'd3
	} uop_op_t;

	typedef struct packed {
		uop_op_t          op;
		logic [RF_AW-1:0] src_a;
		logic [RF_AW-1:0] src_b;
		logic [RF_AW-1:0] dst;
		logic             last;
	} uop_t;

	typedef enum logic {
		ALU_DIV = 1'b0,
		ALU_MUL = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} alu_rsp_t;

	function automatic uop_t mk(input uop_op_t op, input logic [RF_AW-1:0] a,
		input logic [RF_AW-1:0] b, input logic [RF_AW-1:0] d, input logic l);
		uop_t u;
		u.op    = op;
		u.src_a = a;
		u.src_b = b;
		u.dst   = d;
		u.last  = l;
		return u;
	endfunction

	// Micro-program: sum/difference at PC_SUM, product/quotient at PC_MUL
	function automatic uop_t rau_uop(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = mk(UOP_GCD, R_AD, R_BD, R_G,  1'b0);
			5'd1:  u = mk(UOP_DIV, R_BD, R_G,  R_T1, 1'b0); // fm
			5'd2:  u = mk(UOP_DIV, R_AD, R_G,  R_T2, 1'b0); // fr
			5'd3:  u = mk(UOP_MUL, R_AN, R_T1, R_AN, 1'b0);
			5'd4:  u = mk(UOP_MUL, R_BN, R_T2, R_BN, 1'b0);
			5'd5:  u = mk(UOP_ADD, R_AN, R_BN, R_AN, 1'b0);
			5'd6:  u = mk(UOP_MUL, R_AD, R_T1, R_AD, 1'b0);
			5'd7:  u = mk(UOP_GCD, R_AN, R_AD, R_G,  1'b0);
			5'd8:  u = mk(UOP_DIV, R_AN, R_G,  R_AN, 1'b0);
			5'd9:  u = mk(UOP_DIV, R_AD, R_G,  R_AD, 1'b1);
			5'd16: u = mk(UOP_GCD, R_AN, R_AD, R_G,  1'b0);
			5'd17: u = mk(UOP_DIV, R_AN, R_G,  R_AN, 1'b0);
			5'd18: u = mk(UOP_DIV, R_AD, R_G,  R_AD, 1'b0);
			5'd19: u = mk(UOP_GCD, R_BN, R_BD, R_G,  1'b0);
			5'd20: u = mk(UOP_DIV, R_BN, R_G,  R_BN, 1'b0);
			5'd21: u = mk(UOP_DIV, R_BD, R_G,  R_BD, 1'b0);
			5'd22: u = mk(UOP_GCD, R_AN, R_BD, R_G,  1'b0);
			5'd23: u = mk(UOP_GCD, R_BN, R_AD, R_G1, 1'b0);
			5'd24: u = mk(UOP_DIV, R_AN, R_G,  R_T1, 1'b0);
			5'd25: u = mk(UOP_DIV, R_BN, R_G1, R_T2, 1'b0);
			5'd26: u = mk(UOP_MUL, R_T1, R_T2, R_AN, 1'b0);
			5'd27: u = mk(UOP_DIV, R_BD, R_G,  R_T1, 1'b0);
			5'd28: u = mk(UOP_DIV, R_AD, R_G1, R_T2, 1'b0);
			5'd29: u = mk(UOP_MUL, R_T1, R_T2, R_AD, 1'b1);
			default: u = mk(UOP_ADD, R_AN, R_AN, R_AN, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/rau_alu.sv =====
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
module rau_alu #(
	parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rau_pkg::alu_req_t req,
	input  logic [WIDTH-1:0]  a,
	input  logic [WIDTH-1:0]  b,
	output rau_pkg::alu_rsp_t rsp,
	output logic [WIDTH-1:0]  res,
	output logic [WIDTH-1:0]  rem
);
	import rau_pkg::*;

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic             busy_q, done_q;
	alu_op_t          op_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH:0]   hi_q;
	logic [WIDTH-1:0] lo_q, mop_q;
	logic             nega_q, negr_q;

	logic [WIDTH-1:0] ma, mb;
	logic [WIDTH:0]   msum, dr, ddiff;
	logic [WIDTH-1:0] q_mag, p_lo, p_hi;

	assign ma = a[WIDTH-1] ? (~a + 1'b1) : a;
	assign mb = b[WIDTH-1] ? (~b + 1'b1) : b;

	assign msum  = {1'b0, hi_q[WIDTH-1:0]} + {1'b0, (lo_q[0] ? mop_q : '0)};
	assign dr    = {hi_q[WIDTH-1:0], lo_q[WIDTH-1]};
	assign ddiff = dr - {1'b0, mop_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q   <= req.op;
			hi_q   <= '0;
			lo_q   <= (req.op == ALU_MUL) ? mb : ma;
			mop_q  <= (req.op == ALU_MUL) ? ma : mb;
			nega_q <= a[WIDTH-1];
			negr_q <= a[WIDTH-1] ^ b[WIDTH-1];
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				hi_q <= {1'b0, msum[WIDTH:1]};
				lo_q <= {msum[0], lo_q[WIDTH-1:1]};
			end else if (!ddiff[WIDTH]) begin
				hi_q <= ddiff;
				lo_q <= {lo_q[WIDTH-2:0], 1'b1};
			end else begin
				hi_q <= dr;
				lo_q <= {lo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign q_mag = (mop_q == '0) ? '0 : lo_q;
	assign p_lo  = lo_q;
	assign p_hi  = hi_q[WIDTH-1:0];

	always_comb begin
		rsp.done = done_q;
		rem      = nega_q ? (~hi_q[WIDTH-1:0] + 1'b1) : hi_q[WIDTH-1:0];
		if (op_q == ALU_MUL) begin
			res     = negr_q ? (~p_lo + 1'b1) : p_lo;
			rsp.ovf = (|p_hi) ||
				(negr_q ? (p_lo[WIDTH-1] && (|p_lo[WIDTH-2:0])) : p_lo[WIDTH-1]);
		end else begin
			res     = negr_q ? (~q_mag + 1'b1) : q_mag;
			rsp.ovf = !negr_q && q_mag[WIDTH-1];
		end
	end

endmodule

// ===== rtl/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, register file, I/O.
// Flow: the operands are loaded into the register file, then the micro-program
//   runs, each multiply, divide and Euclid step of a GCD going through the
//   shared multiply/divide unit, and the result goes to the output register.
// Throughput: one request at a time; in_ready is high only in idle with no
//   finished result waiting for the output register.
// Error requests (zero denominator, division by zero) skip the sequencer and
//   go straight from acceptance to the pending output.
// Reset: arst_n asynchronous, active low; clears the sequencer and out_valid.
module rational_arith_unit #(
	parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic signed [31:0] res_den,
	output logic [1:0]         status
);
	import rau_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LOAD  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_EXEC  = 8'b0000_1000,
		S_GCD   = 8'b0001_0000,
		S_GWAIT = 8'b0010_0000,
		S_WAIT  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	// sign-extend or truncate a 32-bit field to the datapath width
	function automatic logic [WIDTH-1:0] ext32(input logic [31:0] x);
		logic [63:0] t;
		t = {{32{x[31]}}, x};
		return t[WIDTH-1:0];
	endfunction

	// zero-extend or truncate a datapath value to a 32-bit field
	function automatic logic [31:0] out32(input logic [WIDTH-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[31:0];
	endfunction

	localparam logic [WIDTH-1:0] DSIGN = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] ONE   = {{(WIDTH-1){1'b0}}, 1'b1};

	state_t            state_q;
	logic              done_pend_q;   // finished request waiting for output reg
	logic [PC_W-1:0]   pc_q;
	logic [1:0]        ld_cnt_q;
	logic [WIDTH-1:0]  inp_q [4];
	logic [WIDTH-1:0]  rf_q [RF_DEPTH];
	logic [WIDTH-1:0]  opa_q, opb_q, gx_q, gy_q;
	logic              ovf_q;
	logic [1:0]        err_q;
	logic              out_valid_q;
	logic [31:0]       res_num_q, res_den_q;
	logic [1:0]        status_q;

	uop_t              uop;
	logic              rf_we, step_done, add_ovf;
	logic [RF_AW-1:0]  rf_wa, ra, rb;
	logic [WIDTH-1:0]  rf_wd, sum;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [WIDTH-1:0]  alu_a, alu_b, alu_res, alu_rem;

	// input decode
	logic [WIDTH-1:0]  an_x, ad_x, bn_x, bd_x, bn_neg;
	logic              accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !done_pend_q;
	assign an_x     = ext32(a_num);
	assign ad_x     = ext32(a_den);
	assign bn_x     = ext32(b_num);
	assign bd_x     = ext32(b_den);
	assign bn_neg   = ~bn_x + 1'b1;

	assign uop     = rau_uop(pc_q);
	assign sum     = opa_q + opb_q;
	assign add_ovf = (opa_q[WIDTH-1] == opb_q[WIDTH-1]) && (sum[WIDTH-1] != opa_q[WIDTH-1]);
	// result slots stay on the read port until the output register takes them
	assign ra      = (state_q == S_FIN || state_q == S_IDLE) ? R_AN : uop.src_a;
	assign rb      = (state_q == S_FIN || state_q == S_IDLE) ? R_AD : uop.src_b;

	rau_alu #(.WIDTH(WIDTH)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.res    (alu_res),
		.rem    (alu_rem)
	);

	// register file write port and shared-unit issue
	always_comb begin
		rf_we     = 1'b0;
		rf_wa     = uop.dst;
		rf_wd     = alu_res;
		step_done = 1'b0;
		alu_req   = '{start: 1'b0, op: ALU_DIV};
		alu_a     = opa_q;
		alu_b     = opb_q;
		case (state_q)
			S_LOAD: begin
				rf_we = 1'b1;
				rf_wa = {1'b0, ld_cnt_q};
				rf_wd = inp_q[0];
			end
			S_EXEC: begin
				case (uop.op)
					UOP_ADD: begin
						rf_we     = 1'b1;
						rf_wd     = sum;
						step_done = 1'b1;
					end
					UOP_MUL: alu_req = '{start: 1'b1, op: ALU_MUL};
					UOP_DIV: alu_req = '{start: 1'b1, op: ALU_DIV};
					default: ;
				endcase
			end
			S_GCD: begin
				if (gy_q == '0) begin
					// gcd(0,0) is defined as 1
					rf_we     = 1'b1;
					rf_wd     = (gx_q == '0) ? ONE : gx_q;
					step_done = 1'b1;
				end else begin
					alu_req = '{start: 1'b1, op: ALU_DIV};
					alu_a   = gx_q;
					alu_b   = gy_q;
				end
			end
			S_WAIT: begin
				if (alu_rsp.done) begin
					rf_we     = 1'b1;
					step_done = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_q[rf_wa] <= rf_wd;
		opa_q <= rf_q[ra];
		opb_q <= rf_q[rb];
	end

	// operand capture: shift line drained into the register file during load
	always_ff @(posedge clk) begin
		if (accept) begin
			inp_q[0] <= an_x;
			inp_q[1] <= ad_x;
			case (kind)
				KIND_SUB: begin
					inp_q[2] <= bn_neg;
					inp_q[3] <= bd_x;
				end
				KIND_DIV: begin
					// divide: second operand inverted
					inp_q[2] <= bd_x;
					inp_q[3] <= bn_x;
				end
				default: begin
					inp_q[2] <= bn_x;
					inp_q[3] <= bd_x;
				end
			endcase
		end else if (state_q == S_LOAD) begin
			inp_q[0] <= inp_q[1];
			inp_q[1] <= inp_q[2];
			inp_q[2] <= inp_q[3];
		end
		if (state_q == S_EXEC && uop.op == UOP_GCD) begin
			gx_q <= opa_q;
			gy_q <= opb_q;
		end else if (state_q == S_GWAIT && alu_rsp.done) begin
			gx_q <= gy_q;
			gy_q <= alu_rem;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_pend_q <= 1'b0;
			pc_q        <= '0;
			ld_cnt_q    <= '0;
			ovf_q       <= 1'b0;
			err_q       <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ld_cnt_q <= '0;
						ovf_q    <= (kind == KIND_SUB) && (bn_x == DSIGN);
						pc_q     <= (kind == KIND_MUL || kind == KIND_DIV) ? PC_MUL : PC_SUM;
						if (ad_x == '0 || bd_x == '0) begin
							err_q       <= ST_ZERO_DEN;
							done_pend_q <= 1'b1;
						end else if (kind == KIND_DIV && bn_x == '0) begin
							err_q       <= ST_DIV_ZERO;
							done_pend_q <= 1'b1;
						end else begin
							err_q   <= ST_OK;
							state_q <= S_LOAD;
						end
					end else if (done_pend_q && (!out_valid_q || out_ready)) begin
						done_pend_q <= 1'b0;
					end
				end
				S_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 1'b1;
					if (ld_cnt_q == 2'd3) state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					case (uop.op)
						UOP_GCD: state_q <= S_GCD;
						UOP_ADD: if (add_ovf) ovf_q <= 1'b1;
						default: state_q <= S_WAIT;
					endcase
				end
				S_GCD:   if (gy_q != '0) state_q <= S_GWAIT;
				S_GWAIT: if (alu_rsp.done) state_q <= S_GCD;
				S_WAIT:  if (alu_rsp.done && alu_rsp.ovf) ovf_q <= 1'b1;
				S_FIN: begin
					// operands read from rf[0]/rf[1] in this state; hand to output
					state_q     <= S_IDLE;
					done_pend_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
			if (step_done) begin
				if (uop.last) begin
					state_q <= S_FIN;
				end else begin
					pc_q    <= pc_q + 1'b1;
					state_q <= S_READ;
				end
			end
		end
	end

	// output register: loads when the pending result can go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_IDLE && done_pend_q && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && done_pend_q && (!out_valid_q || out_ready)) begin
			if (err_q != ST_OK) begin
				res_num_q <= '0;
				res_den_q <= '0;
				status_q  <= err_q;
			end else begin
				res_num_q <= out32(opa_q);
				res_den_q <= out32(opb_q);
				status_q  <= ovf_q ? ST_OVF : ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = signed'(res_num_q);
	assign res_den   = signed'(res_den_q);
	assign status    = status_q;

endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] res_num,
	input logic [31:0] res_den,
	input logic [1:0]  status,
	input logic        out_valid,
	input logic        out_ready
);
	import rau_pkg::*;

	// a result held back keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(res_num) && $stable(res_den) && $stable(status))
		else $error("result changed while stalled");

	// one request in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted while busy");

	// error results carry a zero fraction
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO_DEN || status == ST_DIV_ZERO) |->
			res_num == '0 && res_den == '0)
		else $error("error result with nonzero fraction");

	// without overflow the denominator cannot be zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> res_den != '0)
		else $error("zero denominator on clean result");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.res_num   (res_num),
	.res_den   (res_den),
	.status    (status),
	.out_valid (out_valid),
	.out_ready (out_ready)
);

// ===== sim/rational_arith_unit_test.sv =====
// Testbench for rational_arith_unit: directed and random fraction requests checked against a predictor.
`timescale 1ns / 1ps

module rational_arith_unit_test;
	import rau_pkg::*;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t      num;
		word_t      den;
		logic [1:0] st;
	} frac_res_t;

	typedef struct packed {
		logic [1:0] kind;
		word_t      an;
		word_t      ad;
		word_t      bn;
		word_t      bd;
		logic       typed;   // expected result given in the row
		frac_res_t  want;
	} vec_t;

	localparam word_t MIN_W = 32'h8000_0000;
	localparam word_t MAX_W = 32'h7FFF_FFFF;
	localparam int    WATCHDOG_LIMIT = 200000;
	localparam int    HOLD_CYCLES = 4000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        kind = KIND_ADD;
	logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [31:0] res_num, res_den;
	logic [1:0]        status;

	rational_arith_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	frac_res_t pending_q[$];
	int        errors = 0;
	int        sent = 0;
	int        received = 0;
	int        n_err_status = 0;
	int        n_ovf = 0;
	int        send_idle = 22;
	int        recv_idle = 66;
	bit        recv_hold = 1'b0;
	int        quiet_cycles = 0;

	// ---------------- predictor: WIDTH=32 two's complement ----------------
	bit wrap_flag;

	function automatic word_t mag_of(word_t a);
		return a[31] ? -a : a;
	endfunction

	function automatic word_t neg_w(word_t a);
		if (a == MIN_W) wrap_flag = 1'b1;
		return -a;
	endfunction

	function automatic word_t add_w(word_t a, word_t b);
		word_t r;
		r = a + b;
		if (a[31] == b[31] && r[31] != a[31]) wrap_flag = 1'b1;
		return r;
	endfunction

	function automatic word_t mul_w(word_t a, word_t b);
		logic [63:0] p;
		bit          negr;
		negr = a[31] ^ b[31];
		p = {32'd0, mag_of(a)} * {32'd0, mag_of(b)};
		if (negr ? (p > 64'h8000_0000) : (p > 64'h7FFF_FFFF)) wrap_flag = 1'b1;
		return negr ? -p[31:0] : p[31:0];
	endfunction

	// truncating quotient
	function automatic word_t div_w(word_t a, word_t b);
		word_t q, mb;
		bit    negr;
		negr = a[31] ^ b[31];
		mb = mag_of(b);
		q = (mb == 0) ? 32'd0 : mag_of(a) / mb;
		if (!negr && q > MAX_W) wrap_flag = 1'b1;
		return negr ? -q : q;
	endfunction

	// remainder takes the dividend's sign
	function automatic word_t rem_w(word_t a, word_t b);
		word_t r, mb;
		mb = mag_of(b);
		r = (mb == 0) ? mag_of(a) : mag_of(a) % mb;
		return a[31] ? -r : r;
	endfunction

	function automatic word_t gcd_w(word_t x, word_t y);
		word_t t;
		while (y != 0) begin
			t = rem_w(x, y);
			x = y;
			y = t;
		end
		return (x == 0) ? 32'd1 : x;
	endfunction

	function automatic void reduce_w(inout word_t n, inout word_t d);
		word_t g;
		g = gcd_w(n, d);
		n = div_w(n, g);
		d = div_w(d, g);
	endfunction

	function automatic frac_res_t predict_fraction(logic [1:0] k, word_t an, word_t ad,
		word_t bn, word_t bd);
		frac_res_t r;
		word_t     g, g1, fm, fr, xn, xd, yn, yd;
		wrap_flag = 1'b0;
		r = '0;
		if (ad == 0 || bd == 0) begin
			r.st = ST_ZERO_DEN;
		end else if (k == KIND_DIV && bn == 0) begin
			r.st = ST_DIV_ZERO;
		end else if (k == KIND_ADD || k == KIND_SUB) begin
			yn = (k == KIND_SUB) ? neg_w(bn) : bn;
			g  = gcd_w(ad, bd);
			fm = div_w(bd, g);
			fr = div_w(ad, g);
			xn = add_w(mul_w(an, fm), mul_w(yn, fr));
			xd = mul_w(ad, fm);
			reduce_w(xn, xd);
			r.num = xn;
			r.den = xd;
			r.st  = wrap_flag ? ST_OVF : ST_OK;
		end else begin
			// divide swaps the second operand
			xn = an;
			xd = ad;
			yn = (k == KIND_DIV) ? bd : bn;
			yd = (k == KIND_DIV) ? bn : bd;
			reduce_w(xn, xd);
			reduce_w(yn, yd);
			g  = gcd_w(xn, yd);
			g1 = gcd_w(yn, xd);
			r.num = mul_w(div_w(xn, g), div_w(yn, g1));
			r.den = mul_w(div_w(yd, g), div_w(xd, g1));
			r.st  = wrap_flag ? ST_OVF : ST_OK;
		end
		return r;
	endfunction

	// ---------------- request side ----------------
	task automatic offer_request(vec_t v);
		frac_res_t expected_res;
		if (in_valid && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		kind  <= v.kind;
		a_num <= v.an;
		a_den <= v.ad;
		b_num <= v.bn;
		b_den <= v.bd;
		do @(posedge clk); while (!(in_valid && in_ready));
		expected_res = v.typed ? v.want : predict_fraction(v.kind, v.an, v.ad, v.bn, v.bd);
		pending_q.push_back(expected_res);
		sent++;
	endtask

	function automatic word_t rand_operand();
		case ($urandom_range(9))
			0:       return MIN_W;
			1:       return MAX_W;
			2:       return $urandom();
			3:       return $urandom() >> $urandom_range(31);
			4:       return 32'd0;
			default: return $urandom_range(200) - 100;
		endcase
	endfunction

	function automatic vec_t rand_request();
		vec_t v;
		v = '0;
		v.kind = 2'($urandom_range(3));
		v.an = rand_operand();
		v.ad = rand_operand();
		v.bn = rand_operand();
		v.bd = rand_operand();
		// keep zero denominators rare so most requests reach the datapath
		if (v.ad == 0 && $urandom_range(3) != 0) v.ad = 1;
		if (v.bd == 0 && $urandom_range(3) != 0) v.bd = -1;
		return v;
	endfunction

	// ---------------- result side ----------------
	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("mismatch at result %0d: %s got %h expected %h", received, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		frac_res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", {30'd0, status}, 32'd0);
			end else begin
				w = pending_q.pop_front();
				if (res_num !== w.num) report_mismatch("res_num", res_num, w.num);
				if (res_den !== w.den) report_mismatch("res_den", res_den, w.den);
				if (status !== w.st) report_mismatch("status", {30'd0, status}, {30'd0, w.st});
				if (w.st == ST_OVF) n_ovf++;
				if (w.st == ST_ZERO_DEN || w.st == ST_DIV_ZERO) n_err_status++;
			end
			received++;
		end
	end

	// watchdog: cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired: sent %0d received %0d", sent, received);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// long receiver stall so the unit backs up and drops in_ready
	initial begin
		wait (sent >= 330);
		recv_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold = 1'b0;
	end

	// ---------------- directed rows ----------------
	vec_t directed[$];

	function automatic vec_t row(logic [1:0] k, word_t an, word_t ad, word_t bn, word_t bd,
		bit typed = 1'b0, word_t wn = 32'd0, word_t wd = 32'd0, logic [1:0] ws = ST_OK);
		vec_t v;
		v.kind = k; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
		v.typed = typed;
		v.want.num = wn; v.want.den = wd; v.want.st = ws;
		return v;
	endfunction

	initial begin
		vec_t v;
		directed.push_back(row(KIND_ADD, 1, 0, 1, 1, 1'b1, 0, 0, ST_ZERO_DEN));
		directed.push_back(row(KIND_MUL, 1, 1, 1, 0, 1'b1, 0, 0, ST_ZERO_DEN));
		directed.push_back(row(KIND_DIV, 3, 0, 0, 5, 1'b1, 0, 0, ST_ZERO_DEN)); // zero den wins
		directed.push_back(row(KIND_DIV, 3, 4, 0, 5, 1'b1, 0, 0, ST_DIV_ZERO));
		directed.push_back(row(KIND_ADD, 1, 2, 1, 3, 1'b1, 5, 6, ST_OK));
		directed.push_back(row(KIND_SUB, 1, 2, 1, 3));
		directed.push_back(row(KIND_MUL, 2, 3, 9, 4));
		directed.push_back(row(KIND_DIV, -2, 3, 4, -9));
		directed.push_back(row(KIND_ADD, 0, 5, 0, 7));   // both numerators zero
		directed.push_back(row(KIND_MUL, 0, 5, 0, -7));
		directed.push_back(row(KIND_SUB, 1, 1, MIN_W, 1)); // negating the minimum
		directed.push_back(row(KIND_ADD, MAX_W, 1, MAX_W, 1));
		directed.push_back(row(KIND_ADD, MIN_W, 1, MIN_W, 1));
		directed.push_back(row(KIND_MUL, MAX_W, 1, MAX_W, 1));
		directed.push_back(row(KIND_MUL, MIN_W, 1, -1, 1)); // minimum times minus one
		directed.push_back(row(KIND_DIV, MIN_W, 1, -1, 1));
		directed.push_back(row(KIND_DIV, MIN_W, MIN_W, MAX_W, MAX_W));
		directed.push_back(row(KIND_ADD, 1, MAX_W, 1, MAX_W - 1));  // den wraps
		directed.push_back(row(KIND_SUB, -7, -14, 3, -6));
		directed.push_back(row(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
		directed.push_back(row(KIND_DIV, 65536, 3, 1, 65536));
		directed.push_back(row(KIND_ADD, 12, MIN_W, 5, 32'h4000_0000));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) offer_request(directed[i]);

		// random part in three idling regimes
		for (int n = 0; n < 430; n++) begin
			if (n == 150) begin
				send_idle = 66;
				recv_idle = 22;
			end else if (n == 300) begin
				send_idle = 0;
				recv_idle = 0;
			end
			v = rand_request();
			offer_request(v);
		end
		in_valid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered %0d requests over all four operations, %0d results back;", sent,
			received);
		$display("%0d error-status and %0d overflow results seen, with idle and stall phases",
			n_err_status, n_ovf);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
